>>> hw/rtl/pngse_pkg.sv
// Shared types, constants and byte functions of the PNG stored-block encoder.
`default_nettype none
package pngse_pkg;

	localparam int unsigned BLOCK_BYTES = 65535;
	localparam int unsigned ADLER_MOD   = 65521;
	localparam int unsigned CMD_DEPTH   = 4;
	localparam int unsigned OUT_DEPTH   = 4;
	localparam int unsigned START_BYTES = 43;
	localparam int unsigned FIN_BYTES   = 20;

	localparam logic       KIND_START   = 1'b0;
	localparam logic       KIND_PIXEL   = 1'b1;
	localparam logic       CFG_IDX_WIDTH  = 1'b0;
	localparam logic       CFG_IDX_HEIGHT = 1'b1;

	typedef struct packed {
		logic        is_start;
		logic [13:0] w;
		logic [13:0] h;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
		logic        first_of_row;
		logic        last;
	} cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic       lor;
		logic       eof;
	} obyte_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
		end
		return c;
	endfunction

	function automatic logic [7:0] start_const(input logic [5:0] idx);
		logic [7:0] v;
		case (idx)
			6'd0: v = 8'd137;
			6'd1: v = 8'd80;
			6'd2: v = 8'd78;
			6'd3: v = 8'd71;
			6'd4: v = 8'd13;
			6'd5: v = 8'd10;
			6'd6: v = 8'd26;
			6'd7: v = 8'd10;
			6'd11: v = 8'd13;
			6'd12: v = 8'h49;
			6'd13: v = 8'h48;
			6'd14: v = 8'h44;
			6'd15: v = 8'h52;
			6'd24: v = 8'd8;
			6'd25: v = 8'd6;
			6'd37: v = 8'h49;
			6'd38: v = 8'h44;
			6'd39: v = 8'h41;
			6'd40: v = 8'h54;
			6'd41: v = 8'h78;
			6'd42: v = 8'h01;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] iend_const(input logic [1:0] idx);
		logic [7:0] v;
		case (idx)
			2'd0: v = 8'h49;
			2'd1: v = 8'h45;
			2'd2: v = 8'h4E;
			default: v = 8'h44;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pngse_front.sv
// Front end: configuration registers, frame tracking and the command queue.
`default_nettype none
module pngse_front
	import pngse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        kind,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic [7:0]  alpha,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [13:0] cfg_data,
	output cmd_t             cmd,
	output logic             cmd_valid,
	input  wire logic        cmd_pop
);

	localparam int unsigned PW = $clog2(CMD_DEPTH);

	logic [13:0] width_q, height_q, fw_q, fh_q, col_q, row_q;
	logic        open_q;
	cmd_t        queue_q [CMD_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic        accept, enq;
	cmd_t        new_cmd;
	logic [14:0] col_n, row_n;
	logic [13:0] eff_w, eff_h;

	assign cfg_ready = 1'b1;
	assign full      = (cnt_q == (PW+1)'(CMD_DEPTH));
	assign accept    = push && !full;
	assign enq       = accept && ((kind == KIND_START) || open_q);
	assign cmd       = queue_q[rd_q];
	assign cmd_valid = (cnt_q != '0);

	assign eff_w = (width_q == '0) ? 14'd1 : width_q;
	assign eff_h = (height_q == '0) ? 14'd1 : height_q;
	assign col_n = {1'b0, col_q} + 15'd1;
	assign row_n = {1'b0, row_q} + 15'd1;

	always_comb begin
		new_cmd = '0;
		new_cmd.r = red;
		new_cmd.g = green;
		new_cmd.b = blue;
		new_cmd.a = alpha;
		if (kind == KIND_START) begin
			new_cmd.is_start = 1'b1;
			new_cmd.w = eff_w;
			new_cmd.h = eff_h;
		end else begin
			new_cmd.w = fw_q;
			new_cmd.h = fh_q;
			new_cmd.first_of_row = (col_q == '0);
			new_cmd.last = (col_n >= {1'b0, fw_q}) && (row_n >= {1'b0, fh_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 14'd1;
			height_q <= 14'd1;
			fw_q     <= 14'd1;
			fh_q     <= 14'd1;
			col_q    <= '0;
			row_q    <= '0;
			open_q   <= 1'b0;
			wr_q     <= '0;
			rd_q     <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_IDX_WIDTH) begin
					width_q <= cfg_data;
				end else begin
					height_q <= cfg_data;
				end
			end
			if (accept) begin
				if (kind == KIND_START) begin
					fw_q   <= eff_w;
					fh_q   <= eff_h;
					col_q  <= '0;
					row_q  <= '0;
					open_q <= 1'b1;
				end else if (open_q) begin
					if (col_n >= {1'b0, fw_q}) begin
						col_q <= '0;
						row_q <= row_n[13:0];
						if (row_n >= {1'b0, fh_q}) begin
							open_q <= 1'b0;
						end
					end else begin
						col_q <= col_n[13:0];
					end
				end
			end
			if (enq) begin
				wr_q <= wr_q + PW'(1);
			end
			if (cmd_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (enq && !cmd_pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (!enq && cmd_pop) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			queue_q[wr_q] <= new_cmd;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/pngse_back.sv
// Back end: byte sequencer with CRC-32 and Adler-32, and the result queue.
`default_nettype none
module pngse_back
	import pngse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  cmd_t            cmd,
	input  wire logic       cmd_valid,
	output logic            cmd_pop,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            last_of_run,
	output logic            end_of_file
);

	localparam int unsigned PW = $clog2(OUT_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_HDR  = 4'b0010,
		ST_PIX  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t      state_q;
	cmd_t        cur_q;
	logic [5:0]  idx_q;
	logic [2:0]  hidx_q;
	logic [31:0] crc_q;
	logic [15:0] alo_q, ahi_q;
	logic [15:0] blk_left_q;
	logic [29:0] raw_left_q;
	logic [29:0] prod_q;
	logic [14:0] blocks_q;
	logic [31:0] idat_len_q;

	obyte_t      oq_q [OUT_DEPTH];
	logic [PW-1:0] owr_q, ord_q;
	logic [PW:0]   ocnt_q;
	logic        room, emit, opop;

	logic [7:0]  e_byte;
	logic        e_feed, e_seed, e_adler, e_lor, e_eof, e_final;
	logic [31:0] crc_seed, crc_nx, crc_inv;
	logic [15:0] blen, nblen;
	logic        bfinal;
	logic [16:0] alo_sum, ahi_sum;
	logic [15:0] alo_nx, ahi_nx;
	logic [16:0] rem_a;
	logic [13:0] quo_a;
	logic [16:0] rem_b;
	logic [14:0] quo_b;
	obyte_t      head;

	assign room  = (ocnt_q != (PW+1)'(OUT_DEPTH));
	assign emit  = (state_q != ST_IDLE) && room;
	assign opop  = pop && !empty;
	assign empty = (ocnt_q == '0);
	assign head  = oq_q[ord_q];
	assign out_byte    = head.data;
	assign last_of_run = head.lor;
	assign end_of_file = head.eof;
	assign cmd_pop = cmd_valid && ((state_q == ST_IDLE) || (emit && e_final));

	assign crc_inv = ~crc_q;
	assign bfinal  = (raw_left_q <= 30'(BLOCK_BYTES));
	assign blen    = bfinal ? raw_left_q[15:0] : 16'(BLOCK_BYTES);
	assign nblen   = ~blen;

	always_comb begin
		alo_sum = {1'b0, alo_q} + {9'h0, e_byte};
		alo_nx  = (alo_sum >= 17'(ADLER_MOD)) ? 16'(alo_sum - 17'(ADLER_MOD)) : alo_sum[15:0];
		ahi_sum = {1'b0, ahi_q} + {1'b0, alo_nx};
		ahi_nx  = (ahi_sum >= 17'(ADLER_MOD)) ? 16'(ahi_sum - 17'(ADLER_MOD)) : ahi_sum[15:0];
		crc_seed = e_seed ? 32'hFFFFFFFF : crc_q;
		crc_nx   = crc_byte(crc_seed, e_byte);
	end

	always_comb begin
		quo_a = prod_q[29:16];
		rem_a = {1'b0, prod_q[15:0]} + {3'b0, prod_q[29:16]};
		if (rem_a >= 17'(BLOCK_BYTES)) begin
			quo_b = {1'b0, quo_a} + 15'd1;
			rem_b = rem_a - 17'(BLOCK_BYTES);
		end else begin
			quo_b = {1'b0, quo_a};
			rem_b = rem_a;
		end
	end

	always_comb begin
		e_byte  = 8'h00;
		e_feed  = 1'b0;
		e_seed  = 1'b0;
		e_adler = 1'b0;
		e_lor   = 1'b0;
		e_eof   = 1'b0;
		e_final = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				e_byte = 8'h00;
			end
			ST_HDR: begin
				case (idx_q)
					6'd18: e_byte = {2'b00, cur_q.w[13:8]};
					6'd19: e_byte = cur_q.w[7:0];
					6'd22: e_byte = {2'b00, cur_q.h[13:8]};
					6'd23: e_byte = cur_q.h[7:0];
					6'd29: e_byte = crc_inv[31:24];
					6'd30: e_byte = crc_inv[23:16];
					6'd31: e_byte = crc_inv[15:8];
					6'd32: e_byte = crc_inv[7:0];
					6'd33: e_byte = idat_len_q[31:24];
					6'd34: e_byte = idat_len_q[23:16];
					6'd35: e_byte = idat_len_q[15:8];
					6'd36: e_byte = idat_len_q[7:0];
					default: e_byte = start_const(idx_q);
				endcase
				e_feed  = ((idx_q >= 6'd12) && (idx_q <= 6'd28)) || (idx_q >= 6'd37);
				e_seed  = (idx_q == 6'd12) || (idx_q == 6'd37);
				e_final = (idx_q == 6'(START_BYTES - 1));
				e_lor   = e_final;
			end
			ST_PIX: begin
				e_feed = 1'b1;
				if (blk_left_q == '0) begin
					case (hidx_q)
						3'd0: e_byte = {7'h0, bfinal};
						3'd1: e_byte = blen[7:0];
						3'd2: e_byte = blen[15:8];
						3'd3: e_byte = nblen[7:0];
						default: e_byte = nblen[15:8];
					endcase
				end else begin
					case (idx_q[2:0])
						3'd1: e_byte = cur_q.r;
						3'd2: e_byte = cur_q.g;
						3'd3: e_byte = cur_q.b;
						3'd4: e_byte = cur_q.a;
						default: e_byte = 8'h00;
					endcase
					e_adler = 1'b1;
					e_final = (idx_q[2:0] == 3'd4) && !cur_q.last;
					e_lor   = e_final;
				end
			end
			ST_FIN: begin
				case (idx_q[4:2])
					3'd0: begin
						case (idx_q[1:0])
							2'd0: e_byte = ahi_q[15:8];
							2'd1: e_byte = ahi_q[7:0];
							2'd2: e_byte = alo_q[15:8];
							default: e_byte = alo_q[7:0];
						endcase
					end
					3'd1, 3'd4: begin
						case (idx_q[1:0])
							2'd0: e_byte = crc_inv[31:24];
							2'd1: e_byte = crc_inv[23:16];
							2'd2: e_byte = crc_inv[15:8];
							default: e_byte = crc_inv[7:0];
						endcase
					end
					3'd3: e_byte = iend_const(idx_q[1:0]);
					default: e_byte = 8'h00;
				endcase
				e_feed  = (idx_q[4:2] == 3'd0) || (idx_q[4:2] == 3'd3);
				e_seed  = (idx_q == 6'd12);
				e_final = (idx_q == 6'(FIN_BYTES - 1));
				e_lor   = e_final;
				e_eof   = e_final;
			end
			default: e_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q     <= {16'h0, cur_q.h} * {14'h0, cur_q.w, 2'b01};
		blocks_q   <= quo_b + ((rem_b != '0) ? 15'd1 : 15'd0);
		idat_len_q <= 32'd6 + {2'b0, prod_q} + (32'(blocks_q) * 32'd5);
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (emit) begin
			oq_q[owr_q] <= '{data: e_byte, lor: e_lor, eof: e_eof};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			hidx_q     <= '0;
			crc_q      <= 32'hFFFFFFFF;
			alo_q      <= 16'd1;
			ahi_q      <= '0;
			blk_left_q <= '0;
			raw_left_q <= '0;
			owr_q      <= '0;
			ord_q      <= '0;
			ocnt_q     <= '0;
		end else begin
			if (emit) begin
				owr_q <= owr_q + PW'(1);
			end
			if (opop) begin
				ord_q <= ord_q + PW'(1);
			end
			if (emit && !opop) begin
				ocnt_q <= ocnt_q + (PW+1)'(1);
			end else if (!emit && opop) begin
				ocnt_q <= ocnt_q - (PW+1)'(1);
			end
			if (emit) begin
				if (e_feed) begin
					crc_q <= crc_nx;
				end
				if (e_adler) begin
					alo_q <= alo_nx;
					ahi_q <= ahi_nx;
				end
				unique case (state_q)
					ST_HDR: begin
						if (e_final) begin
							alo_q      <= 16'd1;
							ahi_q      <= '0;
							blk_left_q <= '0;
							raw_left_q <= prod_q;
						end else begin
							idx_q <= idx_q + 6'd1;
						end
					end
					ST_PIX: begin
						if (blk_left_q == '0) begin
							if (hidx_q == 3'd4) begin
								hidx_q     <= '0;
								blk_left_q <= blen;
							end else begin
								hidx_q <= hidx_q + 3'd1;
							end
						end else begin
							blk_left_q <= blk_left_q - 16'd1;
							if (raw_left_q != '0) begin
								raw_left_q <= raw_left_q - 30'd1;
							end
							if (idx_q[2:0] == 3'd4) begin
								if (cur_q.last) begin
									idx_q   <= '0;
									state_q <= ST_FIN;
								end
							end else begin
								idx_q <= idx_q + 6'd1;
							end
						end
					end
					ST_FIN: begin
						if (!e_final) begin
							idx_q <= idx_q + 6'd1;
						end
					end
					default: begin
						idx_q <= idx_q;
					end
				endcase
			end
			if (cmd_pop) begin
				hidx_q <= '0;
				if (cmd.is_start) begin
					state_q <= ST_HDR;
					idx_q   <= '0;
				end else begin
					state_q <= ST_PIX;
					idx_q   <= cmd.first_of_row ? 6'd0 : 6'd1;
				end
			end else if (emit && e_final) begin
				state_q <= ST_IDLE;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/png_rgba8_stored_encoder_top.sv
// Top level of the RGBA8 PNG encoder with uncompressed zlib stored blocks.
// Throughput: one file byte per cycle while the result queue has room; a pixel is four or five
// bytes, a start item 43 bytes, a stored-block header five more and the last pixel 20 more.
// The byte sequencer in the back end sets the rate.
// Reset clears both queues and all frame state; sizes return to one by one.
`default_nettype none
module png_rgba8_stored_encoder_top
	import pngse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        kind,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic [7:0]  alpha,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic             end_of_file,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [13:0] cfg_data
);

	cmd_t cmd;
	logic cmd_valid, cmd_pop;

	pngse_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.red(red), .green(green), .blue(blue), .alpha(alpha),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_pop(cmd_pop)
	);

	pngse_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cmd_valid(cmd_valid),
		.cmd_pop(cmd_pop), .empty(empty), .pop(pop), .out_byte(out_byte),
		.last_of_run(last_of_run), .end_of_file(end_of_file)
	);

	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("command taken from an empty queue");

	a_eof_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && end_of_file) |-> last_of_run) else $error("file end without run end");

	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable({out_byte, last_of_run, end_of_file})))
		else $error("waiting transaction changed before it was taken");

endmodule
`default_nettype wire
